>>> hdl/spicd_pkg.sv
// Shared types and constants for the serial clock divider search.
// Used by the controller, the datapath and the divider unit; depends on nothing.
package spicd_pkg;

  // Width of the operands of the shared divider (32-bit values plus one carry bit)
  localparam int unsigned OP_W = 33;
  // Largest even prescaler the 8-bit register can hold
  localparam logic [7:0] PRESCALER_MAX = 8'd254;
  localparam logic [7:0] PRESCALER_MIN = 8'd2;
  localparam logic [31:0] PCLK_RESET = 32'd60000000;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEED_GO,
    ST_NEED_WAIT,
    ST_PRE,
    ST_DP1_GO,
    ST_DP1_WAIT,
    ST_MUL,
    ST_ACT_GO,
    ST_ACT_WAIT,
    ST_DONE
  } state_t;

  // Which quotient the shared divider computes
  typedef enum logic [1:0] {
    DIV_NEED,
    DIV_DP1,
    DIV_ACT
  } div_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     ld_need;
    logic     ld_pre;
    logic     ld_dp1;
    logic     ld_prod;
    logic     ld_act;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic fail;
  } dp_status_t;

endpackage

>>> hdl/spicd_div.sv
// Restoring divider, one quotient bit per cycle, OP_W-bit operands.
// Depends on spicd_pkg for the operand width.
module spicd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [spicd_pkg::OP_W-1:0] dividend,
  input  logic [spicd_pkg::OP_W-1:0] divisor,
  output logic                       done,
  output logic [spicd_pkg::OP_W-1:0] quotient
);

  localparam int unsigned W     = spicd_pkg::OP_W;
  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic             done_r;

  logic [W:0]       rem_sh;
  logic [W+1:0]     diff;
  logic             neg;

  // Trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem, quo[W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs};
    neg    = diff[W+1];
  end

  // Control: count steps, register done together with the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done_r  <= 1'b0;
      cnt     <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done_r  <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one quotient bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      quo <= {quo[W-2:0], ~neg};
      rem <= neg ? rem_sh[W-1:0] : diff[W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo;

endmodule

>>> hdl/spicd_dp.sv
// Datapath: clock register, search registers, multiplier and shared divider.
// Depends on spicd_pkg and spicd_div.
module spicd_dp #(
  parameter int unsigned DIVIDER_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_data,
  input  logic [31:0]           target_hz,
  input  spicd_pkg::dp_cmd_t    cmd,
  output spicd_pkg::dp_status_t status,
  output logic [7:0]            prescaler,
  output logic [7:0]            divider,
  output logic [31:0]           actual_hz,
  output logic                  unreachable
);

  localparam int unsigned W      = spicd_pkg::OP_W;
  localparam int unsigned DP1_W  = DIVIDER_BITS + 1;
  localparam int unsigned PROD_W = DP1_W + 8;
  localparam int unsigned EXT_W  = (DP1_W > 8) ? DP1_W : 8;
  localparam logic [DP1_W-1:0] SPAN = DP1_W'(1) << DIVIDER_BITS;

  logic [31:0]       pclk;
  logic [31:0]       target;
  logic [W-1:0]      need;
  logic [7:0]        pre;
  logic              fail;
  logic [DP1_W-1:0]  divp1;
  logic [PROD_W-1:0] prod;
  logic [31:0]       actual;

  logic [W:0]        pre_sum;
  logic [W:0]        pre_raw;
  logic [7:0]        pre_next;
  logic              fail_next;
  logic [W-1:0]      div_a;
  logic [W-1:0]      div_b;
  logic              div_done;
  logic [W-1:0]      quotient;
  logic [DP1_W-1:0]  dp1m1;
  logic [EXT_W-1:0]  dp1_ext;

  // Hold the peripheral clock register
  always_ff @(posedge clk) begin
    if (rst) begin
      pclk <= spicd_pkg::PCLK_RESET;
    end else if (cfg_we) begin
      pclk <= cfg_data;
    end
  end

  // Prescaler: ceil(need/span), min 2, round up to even; max if unreachable
  always_comb begin
    pre_sum   = {1'b0, need} + (W + 1)'(SPAN - 1'b1);
    pre_raw   = pre_sum >> DIVIDER_BITS;
    fail_next = (pre_raw > (W + 1)'(spicd_pkg::PRESCALER_MAX));
    pre_next  = pre_raw[7:0];
    if (pre_next < spicd_pkg::PRESCALER_MIN) begin
      pre_next = spicd_pkg::PRESCALER_MIN;
    end
    if (pre_next[0]) begin
      pre_next = pre_next + 8'd1;
    end
    if (fail_next) begin
      pre_next = spicd_pkg::PRESCALER_MAX;
    end
  end

  // Select operands for the shared divider
  always_comb begin
    case (cmd.div_sel)
      spicd_pkg::DIV_NEED: begin
        div_a = W'(pclk);
        div_b = W'(target) + W'(1);
      end
      spicd_pkg::DIV_DP1: begin
        div_a = need + W'(pre) - W'(1);
        div_b = W'(pre);
      end
      default: begin
        div_a = W'(pclk);
        div_b = W'(prod);
      end
    endcase
  end

  spicd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quotient)
  );

  // Search registers, loaded step by step on controller command
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target <= target_hz;
    end
    if (cmd.ld_need) begin
      need <= quotient + W'(1);
    end
    if (cmd.ld_pre) begin
      pre   <= pre_next;
      divp1 <= SPAN;
    end
    if (cmd.ld_dp1) begin
      divp1 <= quotient[DP1_W-1:0];
    end
    if (cmd.ld_prod) begin
      prod <= PROD_W'(divp1) * PROD_W'(pre);
    end
    if (cmd.ld_act) begin
      actual <= quotient[31:0];
    end
  end

  // Unreachable flag is control state for the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      fail <= 1'b0;
    end else if (cmd.ld_pre) begin
      fail <= fail_next;
    end
  end

  // Drop divider plus one to the 8-bit field
  always_comb begin
    dp1m1   = divp1 - 1'b1;
    dp1_ext = EXT_W'(dp1m1);
  end

  assign status.div_done = div_done;
  assign status.fail     = fail;
  assign prescaler       = pre;
  assign divider         = dp1_ext[7:0];
  assign actual_hz       = actual;
  assign unreachable     = fail;

endmodule

>>> hdl/spicd_ctrl.sv
// Sequencer for the prescaler and divider search.
// Depends on spicd_pkg for state, command and status types.
module spicd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  spicd_pkg::dp_status_t status,
  output spicd_pkg::dp_cmd_t    cmd,
  output logic                  busy,
  output logic                  done
);

  spicd_pkg::state_t state;
  spicd_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spicd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      spicd_pkg::ST_IDLE: begin
        if (start) state_next = spicd_pkg::ST_NEED_GO;
      end
      spicd_pkg::ST_NEED_GO:   state_next = spicd_pkg::ST_NEED_WAIT;
      spicd_pkg::ST_NEED_WAIT: begin
        if (status.div_done) state_next = spicd_pkg::ST_PRE;
      end
      spicd_pkg::ST_PRE:       state_next = spicd_pkg::ST_DP1_GO;
      spicd_pkg::ST_DP1_GO: begin
        // skip the divider quotient when the target is out of reach
        state_next = status.fail ? spicd_pkg::ST_MUL : spicd_pkg::ST_DP1_WAIT;
      end
      spicd_pkg::ST_DP1_WAIT: begin
        if (status.div_done) state_next = spicd_pkg::ST_MUL;
      end
      spicd_pkg::ST_MUL:       state_next = spicd_pkg::ST_ACT_GO;
      spicd_pkg::ST_ACT_GO:    state_next = spicd_pkg::ST_ACT_WAIT;
      spicd_pkg::ST_ACT_WAIT: begin
        if (status.div_done) state_next = spicd_pkg::ST_DONE;
      end
      spicd_pkg::ST_DONE:      state_next = spicd_pkg::ST_IDLE;
      default:                 state_next = spicd_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd         = '0;
    cmd.div_sel = spicd_pkg::DIV_NEED;
    unique case (state)
      spicd_pkg::ST_IDLE:      cmd.load = start;
      spicd_pkg::ST_NEED_GO:   cmd.div_start = 1'b1;
      spicd_pkg::ST_NEED_WAIT: cmd.ld_need = status.div_done;
      spicd_pkg::ST_PRE:       cmd.ld_pre = 1'b1;
      spicd_pkg::ST_DP1_GO: begin
        cmd.div_sel   = spicd_pkg::DIV_DP1;
        cmd.div_start = ~status.fail;
      end
      spicd_pkg::ST_DP1_WAIT: begin
        cmd.div_sel = spicd_pkg::DIV_DP1;
        cmd.ld_dp1  = status.div_done;
      end
      spicd_pkg::ST_MUL:       cmd.ld_prod = 1'b1;
      spicd_pkg::ST_ACT_GO: begin
        cmd.div_sel   = spicd_pkg::DIV_ACT;
        cmd.div_start = 1'b1;
      end
      spicd_pkg::ST_ACT_WAIT: begin
        cmd.div_sel = spicd_pkg::DIV_ACT;
        cmd.ld_act  = status.div_done;
      end
      spicd_pkg::ST_DONE:      cmd = '0;
      default:                 cmd = '0;
    endcase
  end

  assign busy = (state != spicd_pkg::ST_IDLE);
  assign done = (state == spicd_pkg::ST_DONE);

endmodule

>>> hdl/spi_clock_divider_search.sv
// Top level of the serial clock prescaler and divider search.
// Depends on spicd_pkg, spicd_ctrl and spicd_dp.
//
//  channel   handshake              word
//  --------  ---------------------  ---------------------------------------
//  request   start & !busy          target_hz
//  result    done (one cycle)       prescaler, divider, actual_hz, unreachable
//  config    cfg_valid & cfg_ready  cfg_data (peripheral clock, hertz)
//
// A request makes three 33-step passes through the shared restoring
// divider (two when the target is out of reach), with sequencing states
// between the passes.
// Busy rises after accept, holds through done, then drops; one word in flight.
// Reset sets the peripheral clock to 60 MHz and returns the sequencer to idle.
// The result cannot be stalled; cfg_ready is high only while idle.
module spi_clock_divider_search #(
  parameter int unsigned DIVIDER_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] target_hz,
  output logic        done,
  output logic [7:0]  prescaler,
  output logic [7:0]  divider,
  output logic [31:0] actual_hz,
  output logic        unreachable,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  spicd_pkg::dp_cmd_t    cmd;
  spicd_pkg::dp_status_t status;

  // Take config words only while idle
  assign cfg_ready = ~busy;

  spicd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  spicd_dp #(
    .DIVIDER_BITS (DIVIDER_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_data    (cfg_data),
    .target_hz   (target_hz),
    .cmd         (cmd),
    .status      (status),
    .prescaler   (prescaler),
    .divider     (divider),
    .actual_hz   (actual_hz),
    .unreachable (unreachable)
  );

endmodule

>>> hdl/spicd_chk.sv
// Port-level checks for the divider search, bound to the top level.
// Depends on spi_clock_divider_search ports only.
module spicd_chk (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [7:0] prescaler,
  input logic       unreachable,
  input logic       cfg_ready
);

  // Accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Result word appears only while busy and releases the block
  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |-> (busy ##1 !busy))
    else $error("done outside a busy window or busy held after done");

  // Prescaler is even and within range on a result
  a_pre_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (!prescaler[0] && prescaler >= 8'd2 && prescaler <= 8'd254))
    else $error("prescaler out of range");

  // Out-of-reach result uses the largest prescaler
  a_unreach_max: assert property (@(posedge clk) disable iff (rst)
    (done && unreachable) |-> (prescaler == 8'd254))
    else $error("unreachable result without largest prescaler");

  // Config is taken only while idle
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !busy)
    else $error("config ready while busy");

endmodule

bind spi_clock_divider_search spicd_chk u_spicd_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .prescaler   (prescaler),
  .unreachable (unreachable),
  .cfg_ready   (cfg_ready)
);

>>> tb/spi_clock_divider_search_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for spi_clock_divider_search. It sends target frequencies under several
// peripheral clock settings and checks each answer against a built-in divider search predictor.
// Depends on spicd_pkg and the spi_clock_divider_search RTL.
module spi_clock_divider_search_tb;

  localparam int unsigned DIV_BITS     = 8;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 150;
  // Largest product prescaler * (divider + 1) the block can reach
  localparam longint unsigned REACH_MAX = 64'd254 << DIV_BITS;

  typedef struct {
    logic [31:0] target;
    logic [31:0] pclk;
    logic [7:0]  prescaler;
    logic [7:0]  divider;
    logic [31:0] actual_hz;
    logic        unreachable;
  } clock_choice_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] target_hz = '0;
  logic        done;
  logic [7:0]  prescaler;
  logic [7:0]  divider;
  logic [31:0] actual_hz;
  logic        unreachable;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  logic [31:0]   targets_to_send[$];
  clock_choice_t awaited_choices[$];
  logic [31:0]   pclk_now = spicd_pkg::PCLK_RESET;

  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned out_of_reach = 0;
  int unsigned settings_used = 1;
  int unsigned quiet_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;

  spi_clock_divider_search #(
    .DIVIDER_BITS(DIV_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .target_hz(target_hz),
    .done(done),
    .prescaler(prescaler),
    .divider(divider),
    .actual_hz(actual_hz),
    .unreachable(unreachable),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Smallest even prescaler first, then smallest divider, so that pclk / product <= goal
  function automatic clock_choice_t predict_search(input logic [31:0] goal,
                                                   input logic [31:0] pclk);
    clock_choice_t   r;
    longint unsigned span;
    longint unsigned need;
    longint unsigned pre;
    longint unsigned dp1;
    span = 64'd1 << DIV_BITS;
    // floor(pclk / m) <= goal holds exactly when m exceeds pclk / (goal + 1)
    need = {32'd0, pclk} / ({32'd0, goal} + 64'd1) + 64'd1;
    pre = (need + span - 1) / span;
    if (pre < 64'(spicd_pkg::PRESCALER_MIN)) pre = 64'(spicd_pkg::PRESCALER_MIN);
    if (pre[0]) pre = pre + 1;
    r.unreachable = 1'b0;
    if (pre > 64'(spicd_pkg::PRESCALER_MAX)) begin
      r.unreachable = 1'b1;
      pre = 64'(spicd_pkg::PRESCALER_MAX);
      dp1 = span;
    end else begin
      dp1 = (need + pre - 1) / pre;
      if (dp1 < 1) dp1 = 1;
    end
    r.target    = goal;
    r.pclk      = pclk;
    r.prescaler = pre[7:0];
    r.divider   = 8'((dp1 - 1) & 64'hFF);
    r.actual_hz = 32'({32'd0, pclk} / (dp1 * pre));
    return r;
  endfunction

  task automatic note_error(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    errors++;
  endtask

  // Queue random targets, shaped around the current peripheral clock
  task automatic add_random(input int unsigned count);
    logic [31:0]     t;
    longint unsigned m;
    repeat (count) begin
      case ($urandom_range(0, 4))
        0: t = $urandom;
        1: t = $urandom_range(0, 2000);
        2: begin
          // land on or beside an exact quotient of the clock
          m = 64'($urandom_range(1, 66000));
          t = 32'({32'd0, pclk_now} / m) + $urandom_range(0, 2) - 1;
        end
        3: t = 32'({32'd0, pclk_now} / REACH_MAX) + $urandom_range(0, 4) - 2;
        default: begin
          if ($urandom_range(0, 3) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 3);
          else t = $urandom_range(0, pclk_now);
        end
      endcase
      targets_to_send.push_back(t);
    end
  endtask

  // Hold until every queued word is sent and every answer is back; sample between edges
  task automatic wait_until_drained();
    @(negedge clk);
    while (targets_to_send.size() != 0 || start || awaited_choices.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  // Request driver: bursts of back-to-back words separated by random gaps
  always @(posedge clk) begin : send_words
    logic        start_n;
    logic [31:0] target_n;
    start_n  = start;
    target_n = target_hz;
    if (rst) begin
      start_n  = 1'b0;
      target_n = '0;
    end else begin
      // record the accepted word with its expected answer
      if (start && !busy) begin
        awaited_choices.push_back(predict_search(target_hz, pclk_now));
        start_n = 1'b0;
      end
      // present the next word unless a gap is still running
      if (!start_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (targets_to_send.size() > 0) begin
          start_n  = 1'b1;
          target_n = targets_to_send.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 7);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 140);
          end
        end
      end
    end
    start     <= start_n;
    target_hz <= target_n;
  end

  // Result monitor: compare each strobed answer with the oldest expectation
  always @(posedge clk) begin : check_results
    clock_choice_t want;
    if (!rst && done) begin
      if (awaited_choices.size() == 0) begin
        note_error($sformatf("unexpected result pre %0d div %0d actual %0d unreachable %0b",
                             prescaler, divider, actual_hz, unreachable));
      end else begin
        want = awaited_choices.pop_front();
        checked++;
        if (want.unreachable) out_of_reach++;
        if (prescaler !== want.prescaler)
          note_error($sformatf("target %0d pclk %0d: prescaler %0d, want %0d",
                               want.target, want.pclk, prescaler, want.prescaler));
        if (divider !== want.divider)
          note_error($sformatf("target %0d pclk %0d: divider %0d, want %0d",
                               want.target, want.pclk, divider, want.divider));
        if (actual_hz !== want.actual_hz)
          note_error($sformatf("target %0d pclk %0d: actual_hz %0d, want %0d",
                               want.target, want.pclk, actual_hz, want.actual_hz));
        if (unreachable !== want.unreachable)
          note_error($sformatf("target %0d pclk %0d: unreachable %0b, want %0b",
                               want.target, want.pclk, unreachable, want.unreachable));
      end
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long
  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] settings[$];
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset clock of 60 MHz
    targets_to_send.push_back(32'd0);           // zero target, out of reach
    targets_to_send.push_back(32'd1);
    targets_to_send.push_back(32'hFFFF_FFFF);   // largest target, prescaler 2 divider 0
    targets_to_send.push_back(32'hFFFF_FFFE);
    targets_to_send.push_back(32'h8000_0000);
    targets_to_send.push_back(32'd60_000_000);
    targets_to_send.push_back(32'd30_000_000);  // exactly pclk / 2
    targets_to_send.push_back(32'd29_999_999);
    targets_to_send.push_back(32'd234_375);     // pclk / 256
    targets_to_send.push_back(32'd117_188);     // around divider limit at prescaler 2
    targets_to_send.push_back(32'd117_187);
    targets_to_send.push_back(32'd117_186);
    targets_to_send.push_back(32'd924);         // edge of reach with the largest pair
    targets_to_send.push_back(32'd923);
    targets_to_send.push_back(32'd922);
    targets_to_send.push_back(32'd921);         // just out of reach
    targets_to_send.push_back(32'd1_000_000);
    targets_to_send.push_back(32'd12_345_678);
    targets_to_send.push_back(32'h0001_0000);
    targets_to_send.push_back(32'h5555_5555);
    add_random(25);

    // Peripheral clock settings: extremes, zero, typical and random
    settings.push_back(32'hFFFF_FFFF);
    settings.push_back(32'd1);
    settings.push_back(32'd0);
    settings.push_back(32'd48_000_000);
    settings.push_back($urandom);
    settings.push_back(spicd_pkg::PCLK_RESET);

    foreach (settings[i]) begin
      wait_until_drained();
      cfg_data  <= settings[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      cfg_data  <= '0;
      pclk_now = settings[i];
      settings_used++;
      add_random(41);
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d answers under %0d peripheral clock settings", checked, settings_used);
    $display("%0d targets were out of reach; %0d mismatches", out_of_reach, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/spicd_pkg.sv
hdl/spicd_div.sv
hdl/spicd_dp.sv
hdl/spicd_ctrl.sv
hdl/spi_clock_divider_search.sv
hdl/spicd_chk.sv
tb/spi_clock_divider_search_tb.sv
